[rtl/core/fsa_pkg.sv]
// ----------------------------------------------------------------------------
// fsa_pkg
// Shared codes, widths and types of the falling-sand lattice block.
// ----------------------------------------------------------------------------
package fsa_pkg;

   // default lattice side, border included
   localparam int SIDE_DEF = 64;

   // fixed field widths of the item ports
   localparam int CODE_W  = 2;
   localparam int CRD_W   = 6;
   localparam int COUNT_W = 12;

   // cell codes
   localparam logic [CODE_W-1:0] CELL_EMPTY = 2'd0;
   localparam logic [CODE_W-1:0] CELL_SAND  = 2'd1;
   localparam logic [CODE_W-1:0] CELL_WALL  = 2'd2;

   // request codes
   localparam logic [CODE_W-1:0] REQ_WRITE = 2'd0;
   localparam logic [CODE_W-1:0] REQ_READ  = 2'd1;
   localparam logic [CODE_W-1:0] REQ_GEN   = 2'd2;

   // response status codes
   localparam logic [CODE_W-1:0] ST_OK    = 2'd0;
   localparam logic [CODE_W-1:0] ST_RANGE = 2'd1;
   localparam logic [CODE_W-1:0] ST_MASS  = 2'd2;
   localparam logic [CODE_W-1:0] ST_HALT  = 2'd3;

   typedef enum logic [2:0] {
      FSM_CLEAR,
      FSM_IDLE,
      FSM_ACCESS,
      FSM_READ,
      FSM_SWEEP,
      FSM_DRAIN,
      FSM_REPLY
   } fsm_state_type;

   // one evaluated interior cell from the window
   typedef struct packed {
      logic              vld;
      logic              old_sand;
      logic              new_sand;
      logic [CODE_W-1:0] nxt;
   } eval_type;

endpackage

[rtl/core/falling_sand_automaton_step.sv]
// ----------------------------------------------------------------------------
// falling_sand_automaton_step
// Falling-sand lattice held in one synchronous memory; cell write and read
// items, and generation items that sweep the lattice through a line-buffered
// window, first to count and then to write back.
// ----------------------------------------------------------------------------
// sequence: range error, halted and unknown items go from idle to reply; writes
//   pass through access, reads through access and read
// generation: two raster passes at one cell per cycle on the lattice read port,
//   each followed by a drain of the window; mass lost after the first pass ends
//   the item with no write back
// throughput: one item at a time, the next is taken once the result is staged
// reset: a clearing pass writes the border and empty interior; no item is
//   taken during it
// ----------------------------------------------------------------------------
module falling_sand_automaton_step #(
   parameter int SIDE = fsa_pkg::SIDE_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [fsa_pkg::CODE_W-1:0]  req_type,
   input  logic [fsa_pkg::CRD_W-1:0]   req_col,
   input  logic [fsa_pkg::CRD_W-1:0]   req_row,
   input  logic [fsa_pkg::CODE_W-1:0]  req_cell_state,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [fsa_pkg::CODE_W-1:0]  rsp_read_state,
   output logic [fsa_pkg::COUNT_W-1:0] rsp_sand_count,
   output logic [fsa_pkg::CODE_W-1:0]  rsp_status
);

   localparam int IW        = $clog2(SIDE);
   localparam int LAT_AW    = 2 * IW;
   localparam int LAT_DEPTH = 2 ** LAT_AW;
   localparam int CNT_W     = $clog2((SIDE - 4) * (SIDE - 4) + 1);
   localparam int CW        = fsa_pkg::CODE_W;

   fsa_pkg::fsm_state_type state_ff, state_in;

   logic [CW-1:0]  req_type_ff, req_type_in;
   logic [IW-1:0]  req_col_ff, req_col_in, req_row_ff, req_row_in;
   logic [CW-1:0]  req_cs_ff, req_cs_in;
   logic           halted_ff, halted_in;
   logic           pass_ff, pass_in;
   logic [IW-1:0]  cur_col_ff, cur_col_in, cur_row_ff, cur_row_in;
   logic [CNT_W-1:0] old_cnt_ff, old_cnt_in, new_cnt_ff, new_cnt_in;
   logic [CW-1:0]  res_read_ff, res_read_in;
   logic [fsa_pkg::COUNT_W-1:0] res_count_ff, res_count_in;
   logic [CW-1:0]  res_status_ff, res_status_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]  rsp_read_ff, rsp_read_in;
   logic [fsa_pkg::COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic [CW-1:0]  rsp_status_ff, rsp_status_in;

   // lattice memory, address is {row, col}
   logic [CW-1:0]     lat_mem [LAT_DEPTH];
   logic [CW-1:0]     lat_q_ff;
   logic              lat_we;
   logic [LAT_AW-1:0] lat_waddr, lat_raddr;
   logic [CW-1:0]     lat_wdata;

   logic              issue_vld;
   fsa_pkg::eval_type cell_eval;
   logic [IW-1:0]     eval_col, eval_row;
   logic              win_busy;
   logic              rsp_take;
   logic              in_range, border;

   fsa_window #(.SIDE(SIDE)) u_window (
      .clock     (clock),
      .reset     (reset),
      .issue_vld (issue_vld),
      .issue_col (cur_col_ff),
      .issue_row (cur_row_ff),
      .lat_rdata (lat_q_ff),
      .cell_eval (cell_eval),
      .eval_col  (eval_col),
      .eval_row  (eval_row),
      .busy      (win_busy)
   );

   always_ff @(posedge clock) begin
      if (lat_we) begin
         lat_mem[lat_waddr] <= lat_wdata;
      end
      lat_q_ff <= lat_mem[lat_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fsa_pkg::FSM_CLEAR;
         halted_ff    <= 1'b0;
         pass_ff      <= 1'b0;
         cur_col_ff   <= '0;
         cur_row_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         halted_ff    <= halted_in;
         pass_ff      <= pass_in;
         cur_col_ff   <= cur_col_in;
         cur_row_ff   <= cur_row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_type_ff   <= req_type_in;
      req_col_ff    <= req_col_in;
      req_row_ff    <= req_row_in;
      req_cs_ff     <= req_cs_in;
      old_cnt_ff    <= old_cnt_in;
      new_cnt_ff    <= new_cnt_in;
      res_read_ff   <= res_read_in;
      res_count_ff  <= res_count_in;
      res_status_ff <= res_status_in;
      rsp_read_ff   <= rsp_read_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign in_range = (int'(req_col) < SIDE) && (int'(req_row) < SIDE);
   assign border   = (int'(cur_col_ff) < 2) || (int'(cur_row_ff) < 2) ||
                     (int'(cur_col_ff) >= SIDE - 2) || (int'(cur_row_ff) >= SIDE - 2);
   assign rsp_take = rsp_valid_ff && !rsp_stall;

   always_comb begin
      state_in      = state_ff;
      req_type_in   = req_type_ff;
      req_col_in    = req_col_ff;
      req_row_in    = req_row_ff;
      req_cs_in     = req_cs_ff;
      halted_in     = halted_ff;
      pass_in       = pass_ff;
      cur_col_in    = cur_col_ff;
      cur_row_in    = cur_row_ff;
      old_cnt_in    = old_cnt_ff;
      new_cnt_in    = new_cnt_ff;
      res_read_in   = res_read_ff;
      res_count_in  = res_count_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_read_in   = rsp_read_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_status_in = rsp_status_ff;
      req_stall     = 1'b1;
      issue_vld     = 1'b0;
      lat_we        = 1'b0;
      lat_waddr     = {eval_row, eval_col};
      lat_wdata     = cell_eval.nxt;
      lat_raddr     = {req_row_ff, req_col_ff};

      if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end

      // first pass counts, second pass writes back
      if (cell_eval.vld) begin
         if (pass_ff) begin
            lat_we = 1'b1;
         end else begin
            old_cnt_in = old_cnt_ff + CNT_W'(cell_eval.old_sand);
            new_cnt_in = new_cnt_ff + CNT_W'(cell_eval.new_sand);
         end
      end

      unique case (state_ff)
         fsa_pkg::FSM_CLEAR: begin
            lat_we    = 1'b1;
            lat_waddr = {cur_row_ff, cur_col_ff};
            lat_wdata = border ? fsa_pkg::CELL_WALL : fsa_pkg::CELL_EMPTY;
            if (cur_col_ff == IW'(SIDE - 1)) begin
               cur_col_in = '0;
               if (cur_row_ff == IW'(SIDE - 1)) begin
                  cur_row_in = '0;
                  state_in   = fsa_pkg::FSM_IDLE;
               end else begin
                  cur_row_in = cur_row_ff + IW'(1);
               end
            end else begin
               cur_col_in = cur_col_ff + IW'(1);
            end
         end
         fsa_pkg::FSM_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               req_type_in   = req_type;
               req_col_in    = IW'(req_col);
               req_row_in    = IW'(req_row);
               req_cs_in     = req_cell_state;
               res_read_in   = '0;
               res_count_in  = '0;
               res_status_in = fsa_pkg::ST_OK;
               if (halted_ff) begin
                  res_status_in = fsa_pkg::ST_HALT;
                  state_in      = fsa_pkg::FSM_REPLY;
               end else begin
                  case (req_type) inside
                     fsa_pkg::REQ_WRITE, fsa_pkg::REQ_READ: begin
                        if (in_range) begin
                           state_in = fsa_pkg::FSM_ACCESS;
                        end else begin
                           res_status_in = fsa_pkg::ST_RANGE;
                           state_in      = fsa_pkg::FSM_REPLY;
                        end
                     end
                     fsa_pkg::REQ_GEN: begin
                        cur_col_in = '0;
                        cur_row_in = '0;
                        pass_in    = 1'b0;
                        old_cnt_in = '0;
                        new_cnt_in = '0;
                        state_in   = fsa_pkg::FSM_SWEEP;
                     end
                     default: begin
                        state_in = fsa_pkg::FSM_REPLY;
                     end
                  endcase
               end
            end
         end
         fsa_pkg::FSM_ACCESS: begin
            if (req_type_ff == fsa_pkg::REQ_WRITE) begin
               lat_we    = 1'b1;
               lat_waddr = {req_row_ff, req_col_ff};
               // code 3 saturates to wall
               lat_wdata = (req_cs_ff > fsa_pkg::CELL_WALL) ? fsa_pkg::CELL_WALL : req_cs_ff;
               state_in  = fsa_pkg::FSM_REPLY;
            end else begin
               state_in = fsa_pkg::FSM_READ;
            end
         end
         fsa_pkg::FSM_READ: begin
            res_read_in = lat_q_ff;
            state_in    = fsa_pkg::FSM_REPLY;
         end
         fsa_pkg::FSM_SWEEP: begin
            issue_vld = 1'b1;
            lat_raddr = {cur_row_ff, cur_col_ff};
            // the last row is never needed below an interior centre
            if (cur_col_ff == IW'(SIDE - 1)) begin
               cur_col_in = '0;
               if (cur_row_ff == IW'(SIDE - 2)) begin
                  cur_row_in = '0;
                  state_in   = fsa_pkg::FSM_DRAIN;
               end else begin
                  cur_row_in = cur_row_ff + IW'(1);
               end
            end else begin
               cur_col_in = cur_col_ff + IW'(1);
            end
         end
         fsa_pkg::FSM_DRAIN: begin
            if (!win_busy) begin
               res_count_in = fsa_pkg::COUNT_W'(new_cnt_ff);
               if (pass_ff) begin
                  res_status_in = fsa_pkg::ST_OK;
                  state_in      = fsa_pkg::FSM_REPLY;
               end else if (old_cnt_ff != new_cnt_ff) begin
                  halted_in     = 1'b1;
                  res_status_in = fsa_pkg::ST_MASS;
                  state_in      = fsa_pkg::FSM_REPLY;
               end else begin
                  pass_in  = 1'b1;
                  state_in = fsa_pkg::FSM_SWEEP;
               end
            end
         end
         fsa_pkg::FSM_REPLY: begin
            if (!rsp_valid_ff || rsp_take) begin
               rsp_valid_in  = 1'b1;
               rsp_read_in   = res_read_ff;
               rsp_count_in  = res_count_ff;
               rsp_status_in = res_status_ff;
               state_in      = fsa_pkg::FSM_IDLE;
            end
         end
         default: begin
            state_in = fsa_pkg::FSM_IDLE;
         end
      endcase
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_state = rsp_read_ff;
   assign rsp_sand_count = rsp_count_ff;
   assign rsp_status     = rsp_status_ff;

endmodule

[rtl/core/fsa_window.sv]
// ----------------------------------------------------------------------------
// fsa_window
// Raster-order neighbourhood window: a two-row line buffer memory feeds a
// three-row by five-column register window, and the update rules are applied
// to its centre cell.
// ----------------------------------------------------------------------------
module fsa_window #(
   parameter int SIDE = fsa_pkg::SIDE_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       issue_vld,
   input  logic [$clog2(SIDE)-1:0]    issue_col,
   input  logic [$clog2(SIDE)-1:0]    issue_row,
   input  logic [fsa_pkg::CODE_W-1:0] lat_rdata,
   output fsa_pkg::eval_type          cell_eval,
   output logic [$clog2(SIDE)-1:0]    eval_col,
   output logic [$clog2(SIDE)-1:0]    eval_row,
   output logic                       busy
);

   localparam int IW = $clog2(SIDE);
   localparam int CW = fsa_pkg::CODE_W;

   logic          p1_vld_ff, p2_vld_ff;
   logic [IW-1:0] p1_col_ff, p1_row_ff, p2_col_ff, p2_row_ff;

   // entry x holds {cell two rows up, cell one row up} of column x
   logic [2*CW-1:0] lb_mem [SIDE];
   logic [2*CW-1:0] lb_q_ff;

   // row 0 is one row above the centre, column 2 is the centre column
   logic [CW-1:0] win_ff [3][5];

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff <= 1'b0;
         p2_vld_ff <= 1'b0;
      end else begin
         p1_vld_ff <= issue_vld;
         p2_vld_ff <= p1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      p1_col_ff <= issue_col;
      p1_row_ff <= issue_row;
      p2_col_ff <= p1_col_ff;
      p2_row_ff <= p1_row_ff;
   end

   always_ff @(posedge clock) begin
      lb_q_ff <= lb_mem[issue_col];
      if (p1_vld_ff) begin
         lb_mem[p1_col_ff] <= {lb_q_ff[CW-1:0], lat_rdata};
      end
   end

   always_ff @(posedge clock) begin
      if (p1_vld_ff) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 4; c++) begin
               win_ff[r][c] <= win_ff[r][c+1];
            end
         end
         win_ff[0][4] <= lb_q_ff[2*CW-1:CW];
         win_ff[1][4] <= lb_q_ff[CW-1:0];
         win_ff[2][4] <= lat_rdata;
      end
   end

   always_comb begin
      logic [CW-1:0] c, s7, s8, s9, s11, s12, s14, s15, s17, s18, s19, s20;
      logic [CW-1:0] nxt;
      c   = win_ff[1][2];
      s7  = win_ff[0][1];
      s8  = win_ff[0][2];
      s9  = win_ff[0][3];
      s11 = win_ff[1][0];
      s12 = win_ff[1][1];
      s14 = win_ff[1][3];
      s15 = win_ff[1][4];
      s17 = win_ff[2][1];
      s18 = win_ff[2][2];
      s19 = win_ff[2][3];
      s20 = win_ff[2][4];
      nxt = c;
      if (c == fsa_pkg::CELL_EMPTY) begin
         if (s8 == fsa_pkg::CELL_SAND) begin
            nxt = fsa_pkg::CELL_SAND;
         end else if (s8 == fsa_pkg::CELL_EMPTY && s9 == fsa_pkg::CELL_SAND &&
                      s14 >= fsa_pkg::CELL_SAND) begin
            nxt = fsa_pkg::CELL_SAND;
         end else if (s7 == fsa_pkg::CELL_SAND && s8 == fsa_pkg::CELL_EMPTY &&
                      s9 != fsa_pkg::CELL_SAND && s11 >= fsa_pkg::CELL_SAND &&
                      s12 >= fsa_pkg::CELL_SAND && s14 != fsa_pkg::CELL_SAND) begin
            nxt = fsa_pkg::CELL_SAND;
         end else begin
            nxt = fsa_pkg::CELL_EMPTY;
         end
      end else if (c == fsa_pkg::CELL_SAND) begin
         if (s18 == fsa_pkg::CELL_EMPTY) begin
            nxt = fsa_pkg::CELL_EMPTY;
         end else if (s12 == fsa_pkg::CELL_EMPTY && s17 == fsa_pkg::CELL_EMPTY) begin
            nxt = fsa_pkg::CELL_EMPTY;
         end else if (s14 == fsa_pkg::CELL_EMPTY && s15 != fsa_pkg::CELL_SAND &&
                      s17 >= fsa_pkg::CELL_SAND && s18 >= fsa_pkg::CELL_SAND &&
                      s19 == fsa_pkg::CELL_EMPTY && s20 != fsa_pkg::CELL_SAND) begin
            nxt = fsa_pkg::CELL_EMPTY;
         end else begin
            nxt = fsa_pkg::CELL_SAND;
         end
      end
      // window is complete only for interior centres
      cell_eval.vld      = p2_vld_ff && (p2_col_ff >= IW'(4)) && (p2_row_ff >= IW'(3));
      cell_eval.old_sand = (c == fsa_pkg::CELL_SAND);
      cell_eval.new_sand = (nxt == fsa_pkg::CELL_SAND);
      cell_eval.nxt      = nxt;
   end

   assign eval_col = p2_col_ff - IW'(2);
   assign eval_row = p2_row_ff - IW'(1);
   assign busy     = p1_vld_ff | p2_vld_ff;

endmodule

[rtl/core/fsa_checker.sv]
// ----------------------------------------------------------------------------
// fsa_checker
// Port-level checks of the falling-sand lattice block, bound to the top level.
// ----------------------------------------------------------------------------
module fsa_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic [fsa_pkg::CODE_W-1:0]  req_type,
   input logic [fsa_pkg::CRD_W-1:0]   req_col,
   input logic [fsa_pkg::CRD_W-1:0]   req_row,
   input logic [fsa_pkg::CODE_W-1:0]  req_cell_state,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic [fsa_pkg::CODE_W-1:0]  rsp_read_state,
   input logic [fsa_pkg::COUNT_W-1:0] rsp_sand_count,
   input logic [fsa_pkg::CODE_W-1:0]  rsp_status
);

   logic mass_seen_ff;

   // sticky once a mass-lost item has been delivered
   always_ff @(posedge clock) begin
      if (reset) begin
         mass_seen_ff <= 1'b0;
      end else if (rsp_valid && !rsp_stall && rsp_status == fsa_pkg::ST_MASS) begin
         mass_seen_ff <= 1'b1;
      end
   end

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && mass_seen_ff |-> rsp_status == fsa_pkg::ST_HALT)
      else $error("item after mass loss not answered as halted");

   a_halt_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == fsa_pkg::ST_HALT |->
         rsp_read_state == fsa_pkg::CELL_EMPTY && rsp_sand_count == '0)
      else $error("halted item carries data");

   a_range_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == fsa_pkg::ST_RANGE |->
         rsp_read_state == fsa_pkg::CELL_EMPTY && rsp_sand_count == '0)
      else $error("range error item carries data");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_read_state) &&
         $stable(rsp_sand_count) && $stable(rsp_status))
      else $error("stalled result item changed");

endmodule

bind falling_sand_automaton_step fsa_checker u_fsa_checker (.*);
